>>> src/bpc_pkg.sv
// Shared types, constants and arithmetic helpers of the box particle collision block.
package bpc_pkg;

  localparam int unsigned FxOne      = 65536;
  localparam int unsigned SqrtFirst  = 4;
  localparam int unsigned SqrtSteps  = 31;
  localparam int unsigned SqrtTopBit = 60;
  localparam int unsigned DistStage  = SqrtFirst + SqrtSteps;
  localparam int unsigned DivFirst   = DistStage + 1;
  localparam int unsigned DivSteps   = 17;
  localparam int unsigned SelStage   = DivFirst + DivSteps;
  localparam int unsigned NumStages  = SelStage + 7;
  localparam int unsigned LastStage  = NumStages - 1;

  typedef enum logic [2:0] {
    CfgCenterX   = 3'd0,
    CfgCenterY   = 3'd1,
    CfgCenterZ   = 3'd2,
    CfgHalfX     = 3'd3,
    CfgHalfY     = 3'd4,
    CfgHalfZ     = 3'd5,
    CfgBounce    = 3'd6,
    CfgDamping   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] v;
    logic [29:0]      r;
    logic [2:0][34:0] dlo;
    logic [2:0][34:0] dhi;
    logic [2:0]       below;
    logic [2:0]       above;
    logic             in_box;
    logic             near;
    logic [2:0][34:0] df;
    logic [2:0][34:0] axd;
    logic [2:0]       axup;
    logic [2:0][18:0] nin;
    logic [39:0]      penin;
    logic [2:0][61:0] sq;
    logic [61:0]      rem;
    logic [62:0]      res;
    logic [30:0]      dlen;
    logic             okout;
    logic [39:0]      penout;
    logic [2:0][46:0] drem;
    logic [2:0][16:0] q;
    logic             hit;
    logic [2:0][18:0] n;
    logic [39:0]      pen;
    logic [2:0][39:0] pn;
    logic [2:0][39:0] t;
    logic [2:0][39:0] np;
    logic [39:0]      vn;
    logic [2:0][39:0] vnorm;
    logic [2:0][39:0] vtan;
    logic [2:0][39:0] ta;
    logic [2:0][39:0] tb;
    logic [2:0][31:0] op;
    logic [2:0][31:0] ov;
  } stage_t;

  // Q16.16 product truncated towards zero.
  function automatic logic signed [39:0] mulq(input logic signed [18:0] a,
                                               input logic signed [39:0] b);
    logic [18:0] ma;
    logic [39:0] mb;
    logic [58:0] prod;
    logic [39:0] sh;
    ma   = a[18] ? 19'(-a) : 19'(a);
    mb   = b[39] ? 40'(-b) : 40'(b);
    prod = 59'(ma) * 59'(mb);
    sh   = prod[55:16];
    return (a[18] ^ b[39]) ? $signed(-sh) : $signed(sh);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [39:0] x);
    if (x > 40'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (x < -40'sd2147483648) begin
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

>>> src/bpc_item_if.sv
// Input channel carrying one particle per beat.
interface bpc_item_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  logic [31:0] vel_z;
  logic [29:0] particle_radius;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, particle_radius,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, particle_radius,
                output ready);
endinterface

>>> src/bpc_result_if.sv
// Output channel carrying one resolved particle per beat.
interface bpc_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_pos_x;
  logic [31:0] new_pos_y;
  logic [31:0] new_pos_z;
  logic [31:0] new_vel_x;
  logic [31:0] new_vel_y;
  logic [31:0] new_vel_z;
  logic        hit;

  modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                  new_vel_z, hit, input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                new_vel_z, hit, output ready);
endinterface

>>> src/box_particle_collision.sv
// Top level: pipelined sphere against axis-aligned box collision resolver.
// The block takes one particle per clock cycle and returns its resolved position and
// velocity. The pipeline depth is set by the 31-step square root of the squared offset
// and the 17-step divider that normalises the offset, each built as one pipeline stage
// per step. While a result waits at the output, the whole pipeline holds and no new
// beat is taken; configuration must be written only while the block is empty.
module box_particle_collision (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  bpc_item_if.sink            item_i,
  bpc_result_if.source        result_o
);
  import bpc_pkg::*;

  logic [2:0][31:0] center_q;
  logic [2:0][29:0] half_q;
  logic [16:0]      bounce_q;
  logic [16:0]      damp_q;
  logic [18:0]      e1;
  logic [18:0]      fd;
  logic             adv;
  stage_t           in_stg;
  stage_t           stg_d [NumStages];
  stage_t           stg_q [NumStages];
  logic [LastStage:0] vld_q;

  function automatic stage_t stage_step(input int unsigned s, input stage_t x,
                                        input logic [2:0][31:0] c,
                                        input logic [2:0][29:0] h,
                                        input logic [18:0] ea, input logic [18:0] fa);
    stage_t              y;
    logic signed [33:0]  lo;
    logic signed [33:0]  hi;
    logic signed [34:0]  dfi;
    logic [34:0]         adf;
    logic [1:0]          ba;
    logic [62:0]         bit_v;
    logic [62:0]         tmp;
    logic [46:0]         dv;
    logic signed [39:0]  acc;
    logic [16:0]         qv;
    y = x;
    if (s == 0) begin
      for (int i = 0; i < 3; i++) begin
        lo = 34'($signed(c[i])) - $signed({4'b0, h[i]});
        hi = 34'($signed(c[i])) + $signed({4'b0, h[i]});
        y.below[i] = 34'($signed(x.p[i])) < lo;
        y.above[i] = 34'($signed(x.p[i])) > hi;
        y.dlo[i] = 35'($signed(x.p[i]) - 35'(lo));
        y.dhi[i] = 35'(35'(hi) - $signed(x.p[i]));
      end
    end else if (s == 1) begin
      y.in_box = ~|(x.below | x.above);
      y.near = 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (x.below[i]) begin
          dfi = $signed(x.dlo[i]);
        end else if (x.above[i]) begin
          dfi = -$signed(x.dhi[i]);
        end else begin
          dfi = '0;
        end
        y.df[i] = dfi;
        adf = dfi[34] ? 35'(-dfi) : 35'(dfi);
        if (adf >= {5'b0, x.r}) begin
          y.near = 1'b0;
        end
        y.axup[i] = $signed(x.dhi[i]) < $signed(x.dlo[i]);
        y.axd[i] = y.axup[i] ? x.dhi[i] : x.dlo[i];
      end
    end else if (s == 2) begin
      ba = 2'd0;
      if ($signed(x.axd[1]) < $signed(x.axd[0])) begin
        ba = 2'd1;
      end
      if ($signed(x.axd[2]) < $signed(x.axd[ba])) begin
        ba = 2'd2;
      end
      for (int i = 0; i < 3; i++) begin
        y.nin[i] = '0;
        y.sq[i] = 62'($signed(x.df[i][30:0]) * $signed(x.df[i][30:0]));
      end
      y.nin[ba] = x.axup[ba] ? 19'(FxOne) : 19'(-$signed(19'(FxOne)));
      y.penin = 40'($signed(x.axd[ba])) + 40'(x.r);
    end else if (s == 3) begin
      y.rem = x.sq[0] + x.sq[1] + x.sq[2];
      y.res = '0;
    end else if (s < DistStage) begin
      bit_v = 63'(1) << (SqrtTopBit - 2 * (s - SqrtFirst));
      tmp = x.res + bit_v;
      if ({1'b0, x.rem} >= tmp) begin
        y.rem = x.rem - tmp[61:0];
        y.res = (x.res >> 1) + bit_v;
      end else begin
        y.res = x.res >> 1;
      end
    end else if (s == DistStage) begin
      y.dlen = x.res[30:0];
      y.okout = !x.in_box && x.near && (x.res[30:0] < {1'b0, x.r}) && (x.res[30:0] != '0);
      y.penout = 40'(x.r) - 40'(x.res[30:0]);
      for (int i = 0; i < 3; i++) begin
        adf = x.df[i][34] ? 35'(-$signed(x.df[i])) : x.df[i];
        y.drem[i] = {1'b0, adf[29:0], 16'b0};
        y.q[i] = '0;
      end
    end else if (s < SelStage) begin
      dv = 47'(x.dlen[29:0]) << (DivSteps - 1 - (s - DivFirst));
      for (int i = 0; i < 3; i++) begin
        if (x.drem[i] >= dv) begin
          y.drem[i] = x.drem[i] - dv;
          y.q[i][DivSteps - 1 - (s - DivFirst)] = 1'b1;
        end
      end
    end else if (s == SelStage) begin
      y.hit = x.in_box || x.okout;
      for (int i = 0; i < 3; i++) begin
        qv = x.q[i];
        if (x.in_box) begin
          y.n[i] = x.nin[i];
        end else if (x.okout) begin
          y.n[i] = x.df[i][34] ? 19'(-$signed({2'b0, qv})) : {2'b0, qv};
        end else begin
          y.n[i] = '0;
        end
      end
      y.pen = x.in_box ? x.penin : (x.okout ? x.penout : '0);
    end else if (s == SelStage + 1) begin
      for (int i = 0; i < 3; i++) begin
        y.pn[i] = mulq($signed(x.n[i]), $signed(x.pen));
        y.t[i] = mulq($signed(x.n[i]), 40'($signed(x.v[i])));
      end
    end else if (s == SelStage + 2) begin
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        y.np[i] = 40'($signed(x.p[i])) + $signed(x.pn[i]);
        acc = acc + $signed(x.t[i]);
      end
      y.vn = acc;
    end else if (s == SelStage + 3) begin
      for (int i = 0; i < 3; i++) begin
        y.vnorm[i] = mulq($signed(x.n[i]), $signed(x.vn));
      end
    end else if (s == SelStage + 4) begin
      for (int i = 0; i < 3; i++) begin
        y.vtan[i] = 40'($signed(x.v[i])) - $signed(x.vnorm[i]);
        y.ta[i] = mulq($signed(ea), $signed(x.vnorm[i]));
      end
    end else if (s == SelStage + 5) begin
      for (int i = 0; i < 3; i++) begin
        y.tb[i] = mulq($signed(fa), $signed(x.vtan[i]));
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        y.op[i] = x.hit ? sat32($signed(x.np[i])) : x.p[i];
        acc = 40'($signed(x.v[i])) - $signed(x.ta[i]) - $signed(x.tb[i]);
        y.ov[i] = (x.hit && x.vn[39]) ? sat32(acc) : x.v[i];
      end
    end
    return y;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      half_q   <= '0;
      bounce_q <= '0;
      damp_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCenterX: center_q[0] <= cfg_wdata_i;
        CfgCenterY: center_q[1] <= cfg_wdata_i;
        CfgCenterZ: center_q[2] <= cfg_wdata_i;
        CfgHalfX:   half_q[0]   <= cfg_wdata_i[29:0];
        CfgHalfY:   half_q[1]   <= cfg_wdata_i[29:0];
        CfgHalfZ:   half_q[2]   <= cfg_wdata_i[29:0];
        CfgBounce:  bounce_q    <= cfg_wdata_i[16:0];
        CfgDamping: damp_q      <= cfg_wdata_i[16:0];
        default: ;
      endcase
    end
  end

  // Coefficients above one are limited to one.
  assign e1 = 19'(FxOne) + ((bounce_q > 17'(FxOne)) ? 19'(FxOne) : 19'(bounce_q));
  assign fd = (damp_q > 17'(FxOne)) ? 19'(FxOne) : 19'(damp_q);

  assign adv          = !vld_q[LastStage] || result_o.ready;
  assign item_i.ready = adv;

  always_comb begin
    in_stg   = '0;
    in_stg.p = {item_i.pos_z, item_i.pos_y, item_i.pos_x};
    in_stg.v = {item_i.vel_z, item_i.vel_y, item_i.vel_x};
    in_stg.r = item_i.particle_radius;
  end

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_comb begin
        stg_d[s] = stage_step(s, in_stg, center_q, half_q, e1, fd);
      end
    end else begin : g_next
      always_comb begin
        stg_d[s] = stage_step(s, stg_q[s-1], center_q, half_q, e1, fd);
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LastStage-1:0], item_i.valid};
    end
  end

  assign result_o.valid     = vld_q[LastStage];
  assign result_o.new_pos_x = stg_q[LastStage].op[0];
  assign result_o.new_pos_y = stg_q[LastStage].op[1];
  assign result_o.new_pos_z = stg_q[LastStage].op[2];
  assign result_o.new_vel_x = stg_q[LastStage].ov[0];
  assign result_o.new_vel_y = stg_q[LastStage].ov[1];
  assign result_o.new_vel_z = stg_q[LastStage].ov[2];
  assign result_o.hit       = stg_q[LastStage].hit;

endmodule

>>> src/bpc_checker.sv
// Port-level checker of the box particle collision block and its binding.
module bpc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_ready_i,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input logic [192:0] out_data_i
);

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result beat dropped while stalled.");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("Result payload changed while stalled.");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("Input refused although the output stage is empty.");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("Input taken while the pipeline is stalled.");

endmodule

bind box_particle_collision bpc_checker u_bpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  ({result_o.new_pos_x, result_o.new_pos_y, result_o.new_pos_z,
                 result_o.new_vel_x, result_o.new_vel_y, result_o.new_vel_z, result_o.hit})
);
